### rtl/core/rvhd_pkg.sv
// ----------------------------------------------------------------------------
// rvhd_pkg
// Shared types and constants for the run-length decoder with varint headers.
// ----------------------------------------------------------------------------
package rvhd_pkg;

	localparam int BYTE_W  = 8;
	localparam int CNT_W   = 28;   // width of repeat count and block size
	localparam int ACC_W   = 29;   // assembled header value
	localparam int PHASE_W = 3;

	// decoder phase codes: header byte index, then packet payload
	localparam logic [PHASE_W-1:0] PH_HDR0 = 3'd0;
	localparam logic [PHASE_W-1:0] PH_HDR1 = 3'd1;
	localparam logic [PHASE_W-1:0] PH_HDR2 = 3'd2;
	localparam logic [PHASE_W-1:0] PH_HDR3 = 3'd3;
	localparam logic [PHASE_W-1:0] PH_DATA = 3'd4;

	// decoder control state
	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic               literal;
		logic               clipped;
	} ctl_t;

	// one result word
	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic [CNT_W-1:0]  repeat_count;
		logic              block_end;
		logic              overflow;
	} res_t;

endpackage

### rtl/core/rle_varint_header_decoder.sv
// ----------------------------------------------------------------------------
// rle_varint_header_decoder
// Decodes a run-length stream with 1 to 4 byte varint packet headers into
// (byte, repeat count) words with block-end and overflow marks.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  cfg       in   cfg_valid/cfg_ready    cfg_data: block_size
//  s_axis    in   s_tvalid/s_tready      s_tdata: in_byte
//  m_axis    out  m_tvalid/m_tready      m_tdata, m_tlast, m_tuser
//
//  A byte in the input register is decoded combinationally into the result
//  register; that path sets the rate: one compressed byte is decoded per
//  cycle while the result register drains. Reset clears the decoder and sets
//  block_size to 4096. A stalled output holds its word; s_tready then stays
//  high only while the input register is empty. cfg_ready is low while
//  either register holds a word.
// ----------------------------------------------------------------------------
module rle_varint_header_decoder import rvhd_pkg::*; #(
	parameter int SIZE_BITS = 28
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CNT_W-1:0]  cfg_data,   // block_size
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,    // in_byte
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [39:0]       m_tdata,    // out_byte[7:0], repeat_count[35:8], zero pad
	output logic              m_tlast,    // block_end
	output logic              m_tuser     // overflow
);

	logic [CNT_W-1:0]     block_size_q;
	logic [SIZE_BITS-1:0] eff_blk;
	logic                 valid_s1;
	logic [BYTE_W-1:0]    byte_s1;
	ctl_t                 ctl_q;
	logic [ACC_W-1:0]     accum_q;
	logic [SIZE_BITS-1:0] left_q;
	logic [SIZE_BITS-1:0] produced_q;
	ctl_t                 ctl_nxt;
	logic [ACC_W-1:0]     accum_nxt;
	logic [SIZE_BITS-1:0] left_nxt;
	logic [SIZE_BITS-1:0] produced_nxt;
	logic                 emit;
	res_t                 res;
	logic                 valid_s2;
	res_t                 res_s2;
	logic                 advance;

	// effective block size: low bits, zero treated as one
	assign eff_blk = (block_size_q[SIZE_BITS-1:0] == '0) ? SIZE_BITS'(1)
	                                                     : block_size_q[SIZE_BITS-1:0];

	// advance the input register when the result register can take a word
	assign advance   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = !valid_s1 && !valid_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	rvhd_decode #(
		.SIZE_BITS (SIZE_BITS)
	) u_decode (
		.in_byte      (byte_s1),
		.ctl          (ctl_q),
		.accum        (accum_q),
		.left         (left_q),
		.produced     (produced_q),
		.eff_blk      (eff_blk),
		.ctl_nxt      (ctl_nxt),
		.accum_nxt    (accum_nxt),
		.left_nxt     (left_nxt),
		.produced_nxt (produced_nxt),
		.emit         (emit),
		.res          (res)
	);

	// decoder state and block size; a config write restarts the decoder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q <= CNT_W'(4096);
			ctl_q        <= '0;
			accum_q      <= '0;
			left_q       <= '0;
			produced_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			block_size_q <= cfg_data;
			ctl_q        <= '0;
			accum_q      <= '0;
			left_q       <= '0;
			produced_q   <= '0;
		end else if (advance) begin
			ctl_q      <= ctl_nxt;
			accum_q    <= accum_nxt;
			left_q     <= left_nxt;
			produced_q <= produced_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= emit;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'b0000, res_s2.repeat_count, res_s2.out_byte};
	assign m_tlast  = res_s2.block_end;
	assign m_tuser  = res_s2.overflow;

	// block accounting never reaches the block size between words
	a_produced_below_block: assert property (@(posedge clk) disable iff (!arst_n)
		produced_q < eff_blk)
		else $error("bytes produced reached block size without restart");

	// a payload length never exceeds what is left of the block
	a_left_fits_block: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_q.phase == PH_DATA) |-> (left_q <= eff_blk - produced_q))
		else $error("packet length exceeds remaining block bytes");

	// phase stays within the header and payload codes
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_q.phase <= PH_DATA)
		else $error("decoder phase out of range");

	// a block-end word restarts the decoder
	a_block_end_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit && res.block_end && !cfg_valid)
		|=> (produced_q == '0 && ctl_q.phase == PH_HDR0))
		else $error("decoder not restarted after block end");

endmodule

### rtl/core/rvhd_decode.sv
// ----------------------------------------------------------------------------
// rvhd_decode
// Next-state and result logic for one compressed byte: header assembly,
// length clipping against the block, literal and fill emission.
// ----------------------------------------------------------------------------
module rvhd_decode import rvhd_pkg::*; #(
	parameter int SIZE_BITS = 28
) (
	input  logic [BYTE_W-1:0]    in_byte,
	input  ctl_t                 ctl,
	input  logic [ACC_W-1:0]     accum,
	input  logic [SIZE_BITS-1:0] left,
	input  logic [SIZE_BITS-1:0] produced,
	input  logic [SIZE_BITS-1:0] eff_blk,
	output ctl_t                 ctl_nxt,
	output logic [ACC_W-1:0]     accum_nxt,
	output logic [SIZE_BITS-1:0] left_nxt,
	output logic [SIZE_BITS-1:0] produced_nxt,
	output logic                 emit,
	output res_t                 res
);

	logic [SIZE_BITS-1:0] remaining;
	logic [SIZE_BITS-1:0] left_dec;
	logic [SIZE_BITS-1:0] count;
	logic [SIZE_BITS:0]   sum;
	logic [ACC_W-1:0]     acc_new;
	logic [CNT_W-1:0]     len;
	logic                 hdr_done;
	logic                 clip;
	logic                 ovf;
	logic                 done;

	// merge the header byte into the accumulator and clip the length
	always_comb begin
		remaining = eff_blk - produced;
		acc_new   = accum;
		hdr_done  = 1'b0;
		unique case (ctl.phase)
			PH_HDR0: begin
				acc_new  = accum | ACC_W'(in_byte[6:0]);
				hdr_done = ~in_byte[7];
			end
			PH_HDR1: begin
				acc_new  = accum | (ACC_W'(in_byte[6:0]) << 7);
				hdr_done = ~in_byte[7];
			end
			PH_HDR2: begin
				acc_new  = accum | (ACC_W'(in_byte[6:0]) << 14);
				hdr_done = ~in_byte[7];
			end
			PH_HDR3: begin
				acc_new  = accum | (ACC_W'(in_byte) << 21);
				hdr_done = 1'b1;
			end
			default: ;
		endcase
		len  = acc_new[ACC_W-1:1];
		clip = len > CNT_W'(remaining);
	end

	// phase step and result selection
	always_comb begin
		ctl_nxt      = ctl;
		accum_nxt    = accum;
		left_nxt     = left;
		produced_nxt = produced;
		emit         = 1'b0;
		count        = '0;
		ovf          = 1'b0;
		left_dec     = left - SIZE_BITS'(1);
		unique case (ctl.phase) inside
			PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3: begin
				if (hdr_done) begin
					ctl_nxt.literal = acc_new[0];
					ctl_nxt.clipped = clip;
					accum_nxt       = '0;
					left_nxt        = clip ? remaining : len[SIZE_BITS-1:0];
					ctl_nxt.phase   = (acc_new[0] && len == '0) ? PH_HDR0 : PH_DATA;
				end else begin
					accum_nxt     = acc_new;
					ctl_nxt.phase = ctl.phase + 3'd1;
				end
			end
			PH_DATA: begin
				if (ctl.literal) begin
					left_nxt = left_dec;
					emit     = 1'b1;
					count    = SIZE_BITS'(1);
					ovf      = (left_dec == '0) && ctl.clipped;
					if (left_dec == '0) begin
						ctl_nxt.phase = PH_HDR0;
					end
				end else begin
					ctl_nxt.phase   = PH_HDR0;
					ctl_nxt.clipped = 1'b0;
					left_nxt        = '0;
					emit            = (left != '0);
					count           = left;
					ovf             = ctl.clipped;
				end
			end
			default: begin
				ctl_nxt      = '0;
				accum_nxt    = '0;
				left_nxt     = '0;
				produced_nxt = '0;
			end
		endcase

		// account the emitted bytes and close the block when full
		sum  = {1'b0, produced} + {1'b0, count};
		done = sum >= {1'b0, eff_blk};
		if (emit) begin
			produced_nxt = sum[SIZE_BITS-1:0];
			if (done) begin
				ctl_nxt      = '0;
				accum_nxt    = '0;
				left_nxt     = '0;
				produced_nxt = '0;
			end
		end

		res.out_byte     = in_byte;
		res.repeat_count = CNT_W'(count);
		res.block_end    = done;
		res.overflow     = ovf;
	end

endmodule
